[hdl/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg: shared types and constants for the SHA-256 stream hasher
// Round constants, initial hash words and the front-to-back command type.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_TAKE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } core_state_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[hdl/sha_queue.sv]
// ----------------------------------------------------------------------------
// sha_queue: command queue between front and back
// Small register FIFO; full/empty from a count.
// ----------------------------------------------------------------------------
module sha_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sha_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output sha_pkg::cmd_t rd_cmd
);
  import sha_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/sha_core.sv]
// ----------------------------------------------------------------------------
// sha_core: buffer, padding, round engine and digest output
// Bytes pack into a 16-word schedule window; one round per cycle.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sha_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   digest_word,
  output logic [2:0]    word_index,
  output logic          last_word
);
  import sha_pkg::*;

  core_state_t state, state_next;

  logic [31:0] w [16];      // schedule window; w[0] is the current round word
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [5:0]  fill_count;
  logic [63:0] message_bits;
  logic [5:0]  round;
  logic        finishing;   // compressing a padded block
  logic        extra_pending; // length block still to come
  logic [2:0]  emit_idx;

  logic [31:0] s0, s1, w_new, e1, ch, e0, mj, t1, t2;
  logic [63:0] len_total;
  logic [31:0] pad_word;
  logic [3:0]  pw;
  logic [1:0]  pb;
  logic        take;

  assign take = (state == ST_TAKE) && cmd_valid;
  assign pw   = fill_count[5:2];
  assign pb   = fill_count[1:0];
  assign len_total = message_bits + {55'd0, fill_count, 3'd0};

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    e1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + e1 + ch + ROUND_K[round] + w[0];
    e0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = e0 + mj;
    // word holding the 0x80 marker: keep bytes ahead of it, zero the rest
    unique case (pb)
      2'd0:    pad_word = 32'h8000_0000;
      2'd1:    pad_word = {w[pw][31:24], 24'h80_0000};
      2'd2:    pad_word = {w[pw][31:16], 16'h8000};
      default: pad_word = {w[pw][31:8], 8'h80};
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_TAKE: if (cmd_valid) begin
        if (cmd.kind) state_next = ST_PAD;
        else if (fill_count == 6'd63) state_next = ST_ROUND;
      end
      ST_PAD:   state_next = ST_ROUND;
      ST_ROUND: if (round == 6'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (!finishing) state_next = ST_TAKE;
        else if (extra_pending) state_next = ST_ROUND;
        else state_next = ST_EMIT;
      end
      ST_EMIT: if (out_ready && emit_idx == 3'd7) state_next = ST_TAKE;
      default: state_next = ST_TAKE;
    endcase
  end

  always_comb begin
    cmd_ready   = (state == ST_TAKE);
    out_valid   = (state == ST_EMIT);
    digest_word = h[emit_idx];
    word_index  = emit_idx;
    last_word   = (emit_idx == 3'd7);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_TAKE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
      fill_count    <= '0;
      message_bits  <= '0;
      round         <= '0;
      finishing     <= 1'b0;
      extra_pending <= 1'b0;
      emit_idx      <= '0;
    end else begin
      unique case (state)
        ST_TAKE: if (take) begin
          if (!cmd.kind) begin
            unique case (pb)
              2'd0:    w[pw][31:24] <= cmd.data_byte;
              2'd1:    w[pw][23:16] <= cmd.data_byte;
              2'd2:    w[pw][15:8]  <= cmd.data_byte;
              default: w[pw][7:0]   <= cmd.data_byte;
            endcase
            fill_count <= fill_count + 1'b1;
            if (fill_count == 6'd63) begin
              message_bits <= message_bits + 64'd512;
              for (int i = 0; i < 8; i++) v[i] <= h[i];
              round     <= '0;
              finishing <= 1'b0;
            end
          end
        end
        ST_PAD: begin
          for (int i = 0; i < 16; i++) begin
            if (4'(i) == pw) w[i] <= pad_word;
            else if (4'(i) > pw) w[i] <= '0;
          end
          if (fill_count < 6'd56) begin
            w[14] <= len_total[63:32];
            w[15] <= len_total[31:0];
            extra_pending <= 1'b0;
          end else begin
            extra_pending <= 1'b1;
          end
          message_bits <= len_total;
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          round     <= '0;
          finishing <= 1'b1;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          for (int j = 1; j < 8; j++) v[j] <= v[j-1];
          v[4]  <= v[3] + t1;
          v[0]  <= t1 + t2;
          round <= round + 1'b1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
            v[i] <= h[i] + v[i];
          end
          round <= '0;
          if (finishing && extra_pending) begin
            for (int i = 0; i < 14; i++) w[i] <= '0;
            w[14] <= message_bits[63:32];
            w[15] <= message_bits[31:0];
            extra_pending <= 1'b0;
          end
          emit_idx <= '0;
        end
        ST_EMIT: if (out_ready) begin
          emit_idx <= emit_idx + 1'b1;
          if (emit_idx == 3'd7) begin
            for (int i = 0; i < 8; i++) h[i] <= INIT_H[i];
            fill_count   <= '0;
            message_bits <= '0;
            finishing    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/sha256_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher: streaming SHA-256 over a byte channel
// Queue front end feeding a one-round-per-cycle compression core.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready): kind, data_byte. kind 0 adds a message byte,
//   kind 1 pads the message, emits its digest and restarts.
//   Output channel (valid/ready): digest_word, word_index, last_word; eight
//   transfers per finish, H0 first, last_word on the eighth.
//   The core takes bytes only in its take state; the 64th byte of a block
//   starts the round engine, which holds the core for 64 rounds plus the
//   chaining add. No byte is taken while the single shared round unit
//   compresses. A finish costs a pad step plus one or two compressions,
//   then 8 output transfers. The input queue keeps taking items, until it
//   is full, while the core compresses or waits on the output; a stalled
//   receiver holds the core in the emit phase.
//   Synchronous reset returns the initial hash words, zero length and an
//   empty queue; the buffer needs no clearing.
// ----------------------------------------------------------------------------
module sha256_stream_hasher #(
  parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  assign in_cmd = '{kind: kind, data_byte: data_byte};

  sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_cmd(in_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_cmd(q_cmd)
  );

  sha_core u_core (
    .clk(clk), .rst(rst),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

endmodule

[tb/sha256_stream_hasher_test.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_test: self-checking bench for the SHA-256 stream hasher
// Directed messages at each padding boundary and random byte messages are
// hashed by a behavioral SHA-256 in the bench; each digest word is checked in order.
// ----------------------------------------------------------------------------
class digest_scoreboard;
  logic [31:0] hash_state [8];
  logic [7:0]  pending [64];
  int unsigned pending_count;
  logic [63:0] length_bits;
  logic [31:0] word_q [$];
  logic [2:0]  index_q [$];
  bit          failed;

  function new();
    restart();
    failed = 0;
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) hash_state[i] = sha_pkg::INIT_H[i];
    pending_count = 0;
    length_bits = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function void compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {pending[4*i], pending[4*i+1], pending[4*i+2], pending[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] += t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  function void note_input(logic kind, logic [7:0] data_byte);
    if (!kind) begin
      pending[pending_count] = data_byte;
      pending_count++;
      if (pending_count == 64) begin
        compress();
        length_bits += 512;
        pending_count = 0;
      end
      return;
    end
    length_bits += pending_count * 8;
    pending[pending_count] = 8'h80;
    for (int i = pending_count + 1; i < 64; i++) pending[i] = '0;
    if (pending_count >= 56) begin
      compress();
      for (int i = 0; i < 56; i++) pending[i] = '0;
    end
    for (int i = 0; i < 8; i++) pending[63-i] = length_bits[8*i +: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      word_q.push_back(hash_state[i]);
      index_q.push_back(i[2:0]);
    end
    restart();
  endfunction

  function void check_result(logic [31:0] word, logic [2:0] idx, logic last);
    logic [31:0] ew;
    logic [2:0]  ei;
    if (word_q.size() == 0) begin
      $display("%0t: unexpected digest word %h", $time, word);
      failed = 1;
      return;
    end
    ew = word_q.pop_front();
    ei = index_q.pop_front();
    if (word !== ew) begin
      $display("%0t: digest_word expected %h actual %h", $time, ew, word);
      failed = 1;
    end
    if (idx !== ei) begin
      $display("%0t: word_index expected %0d actual %0d", $time, ei, idx);
      failed = 1;
    end
    if (last !== (ei == 3'd7)) begin
      $display("%0t: last_word expected %0b actual %0b", $time, ei == 3'd7, last);
      failed = 1;
    end
  endfunction
endclass

module sha256_stream_hasher_test;
  localparam int StallLimit = 20000;
  localparam logic KindByte = 1'b0;
  localparam logic KindFinish = 1'b1;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        kind = 0;
  logic [7:0]  data_byte = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  digest_scoreboard board = new();
  int          burst_left = 0;
  int          idle_cycles = 0;

  sha256_stream_hasher dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .data_byte(data_byte), .out_valid(out_valid),
    .out_ready(out_ready), .digest_word(digest_word),
    .word_index(word_index), .last_word(last_word)
  );

  always #5 clk = ~clk;

  // input bursts with random gaps; valid is held until the transfer
  task automatic send_item(logic k, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1;
    kind <= k;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    board.note_input(k, b);
  endtask

  task automatic send_message(int n);
    for (int i = 0; i < n; i++) send_item(KindByte, 8'($urandom_range(0, 255)));
    send_item(KindFinish, 8'($urandom_range(0, 255)));
  endtask

  // receiver: own stall pattern plus one long hold-off early on
  initial begin
    int phase;
    phase = 0;
    @(negedge rst);
    repeat (30) @(posedge clk);
    out_ready <= 0;
    repeat (400) @(posedge clk);
    forever begin
      @(posedge clk);
      phase++;
      if ((phase / 64) % 3 == 2) out_ready <= 1;
      else out_ready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result(digest_word, word_index, last_word);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("sha256_stream_hasher: mismatch");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: empty, 0xff/0x00 bytes, each padding boundary
    send_message(0);
    send_item(KindByte, 8'hff);
    send_item(KindFinish, 8'h00);
    send_item(KindByte, 8'h00);
    send_item(KindFinish, 8'hff);
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    // random: mostly short messages, an occasional long one
    n = 0;
    while (n < 63) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 140) : $urandom_range(0, 20);
      send_message(len);
      n += len + 1;
    end
    in_valid <= 0;
    while (board.word_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!board.failed) $display("sha256_stream_hasher: match");
    else $display("sha256_stream_hasher: mismatch");
    $finish;
  end
endmodule
